@@ sv/psl_pkg.sv @@
package psl_pkg;

   // Row geometry
   localparam int DEPTH   = 16;
   localparam int DATA_W  = 32;
   localparam int KIND_W  = 3;
   localparam int POS_W   = 5;
   localparam int FIDX_W  = 4;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W   = (IDX_W > POS_W) ? IDX_W : POS_W;

   // Operation codes
   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 3'd0,
      KIND_REMOVE = 3'd1,
      KIND_UPDATE = 3'd2,
      KIND_CLEAR  = 3'd3,
      KIND_FIND   = 3'd4
   } kind_type;

   // Command broadcast to every cell in the row
   typedef struct packed {
      logic                     fire;
      kind_type                 kind;
      logic                     in_range;
      logic [CMP_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
   } cmd_type;

endpackage

@@ sv/psl_cell.sv @@
module psl_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  psl_pkg::cmd_type                 cmd,
   input  logic [psl_pkg::CMP_W-1:0]        cell_idx,
   input  logic signed [psl_pkg::DATA_W-1:0] left_entry,
   input  logic signed [psl_pkg::DATA_W-1:0] right_entry,
   output logic signed [psl_pkg::DATA_W-1:0] entry,
   output logic                             match
);
   import psl_pkg::*;

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic                     match_ff;

   // Pick the next entry from own value, a neighbor, the command value or zero on a clear
   always_comb begin
      entry_in = entry_ff;
      if (cmd.fire) begin
         unique case (cmd.kind)
            KIND_INSERT: begin
               if (cmd.in_range) begin
                  if (cell_idx == cmd.pos) begin
                     entry_in = cmd.value;
                  end else if (cell_idx > cmd.pos) begin
                     entry_in = left_entry;
                  end
               end
            end
            KIND_REMOVE: begin
               if (cmd.in_range && (cell_idx >= cmd.pos)) begin
                  entry_in = right_entry;
               end
            end
            KIND_UPDATE: begin
               if (cmd.in_range && (cell_idx == cmd.pos)) begin
                  entry_in = cmd.value;
               end
            end
            KIND_CLEAR: begin
               entry_in = '0;
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   // Hold the entry; clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   // Capture the key compare against the entry as the beat arrives
   always_ff @(posedge clock) begin
      if (cmd.fire) begin
         match_ff <= (entry_ff == cmd.value);
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

@@ sv/positional_shift_list_top.sv @@
// An accepted request passes the stage register, then the output register.
// One operation per cycle while results are taken; the cells shift, write and
// compare in the accept cycle, and the lowest-match encode reads the matches.
// Result stalls back up through one stage register and the output register.
// Reset (synchronous, active high) zeros every entry and empties both stages;
// the block takes a request in the first cycle after reset.
module positional_shift_list_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [psl_pkg::KIND_W-1:0]        req_kind,
   input  logic [psl_pkg::POS_W-1:0]         req_position,
   input  logic signed [psl_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_ok,
   output logic                              rsp_found,
   output logic [psl_pkg::FIDX_W-1:0]        rsp_found_index
);
   import psl_pkg::*;

   cmd_type                  cmd;
   kind_type                 kind;
   logic                     in_range;
   logic                     op_ok;
   logic signed [DATA_W-1:0] entries [DEPTH];
   logic [DEPTH-1:0]         match_vec;

   logic                     s1_valid_ff;
   logic                     s1_ok_ff;
   logic                     s1_find_ff;
   logic                     s1_adv;

   logic                     rsp_valid_ff;
   logic                     rsp_ok_ff;
   logic                     rsp_found_ff;
   logic [FIDX_W-1:0]        rsp_found_index_ff;

   logic                     hit;
   logic [FIDX_W-1:0]        hit_idx;

   // Decode the request beat
   assign kind     = kind_type'(req_kind);
   assign in_range = (int'(req_position) < DEPTH);

   always_comb begin
      unique case (kind)
         KIND_INSERT, KIND_REMOVE, KIND_UPDATE: op_ok = in_range;
         KIND_CLEAR, KIND_FIND:                 op_ok = 1'b1;
         default:                               op_ok = 1'b0;
      endcase
   end

   // Advance the stage register when the output register is free
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;

   assign cmd.fire     = req_valid && req_ready;
   assign cmd.kind     = kind;
   assign cmd.in_range = in_range;
   assign cmd.pos      = CMP_W'(req_position);
   assign cmd.value    = req_value;

   // Row of cells; the ends see zero from beyond the row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_entry;
      logic signed [DATA_W-1:0] right_entry;

      if (i == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_inner_l
         assign left_entry = entries[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner_r
         assign right_entry = entries[i+1];
      end

      psl_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .cell_idx    (CMP_W'(i)),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entries[i]),
         .match       (match_vec[i])
      );
   end

   // Encode the lowest matching cell
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            hit     = 1'b1;
            hit_idx = FIDX_W'(i);
         end
      end
   end

   // Stage register: status of the beat that the cells just took
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (cmd.fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fire) begin
         s1_ok_ff   <= op_ok;
         s1_find_ff <= (kind == KIND_FIND);
      end
   end

   // Output register: hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_ok_ff          <= s1_ok_ff;
         rsp_found_ff       <= s1_find_ff && hit;
         rsp_found_index_ff <= (s1_find_ff && hit) ? hit_idx : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_index = rsp_found_index_ff;

endmodule

@@ sv/psl_checker.sv @@
module psl_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [psl_pkg::KIND_W-1:0]        req_kind,
   input logic [psl_pkg::POS_W-1:0]         req_position,
   input logic signed [psl_pkg::DATA_W-1:0] req_value,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_ok,
   input logic                              rsp_found,
   input logic [psl_pkg::FIDX_W-1:0]        rsp_found_index
);
   import psl_pkg::*;

   // A stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_found)
         && $stable(rsp_found_index))
      else $error("result beat changed while stalled");

   // A match is only reported by an accepted operation
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_ok)
      else $error("found set without ok");

   // No match leaves the index at zero
   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_found_index == '0)
      else $error("found_index nonzero without a match");

   // Reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Two stages of buffering: a request is never refused with an empty output
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!rsp_valid) && !$past(reset) |-> req_ready)
      else $error("request stalled with an empty output");

endmodule

bind positional_shift_list_top psl_checker u_psl_checker (.*);

@@ test/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import psl_pkg::*;

   // Codes the block has no operation for
   localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

   localparam int RANDOM_OPS    = 1500;
   localparam int IDLE_PCT      = 21;
   localparam int QUIET_FROM    = 700;
   localparam int QUIET_TO      = 1000;
   localparam int BACKUP_AT     = 300;
   localparam int BACKUP_CYCLES = 80;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 10;

   typedef struct {
      logic [KIND_W-1:0]        kind;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
   } list_op_type;

   typedef struct {
      logic              ok;
      logic              found;
      logic [FIDX_W-1:0] found_index;
   } list_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [KIND_W-1:0]           req_kind = '0;
   logic [POS_W-1:0]            req_position = '0;
   logic signed [DATA_W-1:0]    req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_ok;
   logic                        rsp_found;
   logic [FIDX_W-1:0]           rsp_found_index;

   list_op_type              op_queue[$];
   list_result_type          expected_results[$];
   logic signed [DATA_W-1:0] shadow_row[DEPTH];
   logic signed [DATA_W-1:0] value_pool[8];
   int                       req_beats = 0;
   int                       rsp_beats = 0;
   int                       error_count = 0;
   int                       total_ops = 0;
   int                       backup_left = 0;
   bit                       backup_done = 1'b0;
   int                       stall_cycles = 0;

   positional_shift_list_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_found       (rsp_found),
      .rsp_found_index (rsp_found_index)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one operation to the shadow row and return the result it should give
   function automatic list_result_type apply_list_op(list_op_type op);
      list_result_type res;
      bit              in_range;
      res = '{ok: 1'b0, found: 1'b0, found_index: '0};
      in_range = int'(op.pos) < DEPTH;
      case (op.kind)
         KIND_INSERT: begin
            if (in_range) begin
               for (int i = DEPTH - 1; i > int'(op.pos); i--)
                  shadow_row[i] = shadow_row[i-1];
               shadow_row[op.pos] = op.value;
               res.ok = 1'b1;
            end
         end
         KIND_REMOVE: begin
            if (in_range) begin
               for (int i = int'(op.pos); i < DEPTH - 1; i++)
                  shadow_row[i] = shadow_row[i+1];
               shadow_row[DEPTH-1] = '0;
               res.ok = 1'b1;
            end
         end
         KIND_UPDATE: begin
            if (in_range) begin
               shadow_row[op.pos] = op.value;
               res.ok = 1'b1;
            end
         end
         KIND_CLEAR: begin
            foreach (shadow_row[i]) shadow_row[i] = '0;
            res.ok = 1'b1;
         end
         KIND_FIND: begin
            res.ok = 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
               if (!res.found && shadow_row[i] == op.value) begin
                  res.found       = 1'b1;
                  res.found_index = FIDX_W'(i);
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic add_op(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                         logic signed [DATA_W-1:0] value);
      op_queue.push_back('{kind: kind, pos: pos, value: value});
   endtask

   // Mostly draw from a small pool so finds hit and entries repeat
   function automatic logic signed [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 99) < 70)
         return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // Stimulus and end of run
   initial begin
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  pos;
      int                roll;

      foreach (shadow_row[i]) shadow_row[i] = '0;
      value_pool[0] = 0;
      value_pool[1] = -1;
      value_pool[2] = 32'sh7FFF_FFFF;
      value_pool[3] = 32'sh8000_0000;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

      // Directed: extremes, out-of-range positions, unused codes, empty finds
      add_op(KIND_FIND, 5'd0, 0);
      add_op(KIND_INSERT, 5'd0, 32'sh7FFF_FFFF);
      add_op(KIND_INSERT, 5'd15, 32'sh8000_0000);
      add_op(KIND_INSERT, 5'd31, 32'sh1234_5678);
      add_op(KIND_INSERT, 5'd16, 32'sh1234_5678);
      add_op(KIND_UPDATE, 5'd15, -1);
      add_op(KIND_UPDATE, 5'd16, 32'sh5555_5555);
      add_op(KIND_REMOVE, 5'd31, 0);
      add_op(KIND_FIND, 5'd31, -1);
      add_op(KIND_FIND, 5'd0, 32'sh7FFF_FFFF);
      add_op(KIND_FIND, 5'd0, 32'sh0BAD_F00D);
      add_op(KIND_INSERT, 5'd5, 32'shAAAA_AAAA);
      add_op(KIND_INSERT, 5'd5, 32'sh5555_5555);
      add_op(KIND_FIND, 5'd0, 32'shAAAA_AAAA);
      add_op(KIND_REMOVE, 5'd0, 0);
      add_op(KIND_REMOVE, 5'd15, 0);
      add_op(KIND_UPDATE, 5'd0, 32'sh5555_5555);
      add_op(KIND_FIND, 5'd0, 32'sh5555_5555);
      for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++)
         add_op(KIND_W'(k), POS_W'(k), -1);
      add_op(KIND_CLEAR, 5'd31, -1);
      add_op(KIND_FIND, 5'd0, 0);
      add_op(KIND_FIND, 5'd0, 32'sh5555_5555);

      // Random: mostly legal operations on a filling row, some errors and noise
      for (int n = 0; n < RANDOM_OPS; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 30)      kind = KIND_INSERT;
         else if (roll < 45) kind = KIND_REMOVE;
         else if (roll < 63) kind = KIND_UPDATE;
         else if (roll < 65) kind = KIND_CLEAR;
         else if (roll < 95) kind = KIND_FIND;
         else                kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
         if ($urandom_range(0, 99) < 88) pos = POS_W'($urandom_range(0, DEPTH - 1));
         else                            pos = POS_W'($urandom_range(DEPTH, 31));
         add_op(kind, pos, pick_value());
      end
      total_ops = op_queue.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait on the falling edge so the counters have settled
      do @(negedge clock);
      while (req_beats != total_ops || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Request driver: hold the beat until accepted, idle at random outside the quiet stretch
   always @(posedge clock) begin : req_driver
      list_op_type nxt;
      bit          quiet;
      quiet = req_beats >= QUIET_FROM && req_beats < QUIET_TO;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (op_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
            nxt = op_queue.pop_front();
            req_valid    <= 1'b1;
            req_kind     <= nxt.kind;
            req_position <= nxt.pos;
            req_value    <= nxt.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, one long back-up, a quiet stretch
   always @(posedge clock) begin : rsp_receiver
      bit quiet;
      quiet = rsp_beats >= QUIET_FROM && rsp_beats < QUIET_TO;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (backup_left != 0) begin
         backup_left <= backup_left - 1;
         rsp_ready   <= 1'b0;
      end else if (!backup_done && rsp_beats >= BACKUP_AT) begin
         backup_done <= 1'b1;
         backup_left <= BACKUP_CYCLES - 1;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= quiet || $urandom_range(0, 99) >= IDLE_PCT;
      end
   end

   // Monitor: predict on each request beat, check each result beat
   always @(posedge clock) begin : monitor
      list_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_beats <= rsp_beats + 1;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result ok=%0b found=%0b index=%0d", $time,
                        rsp_ok, rsp_found, rsp_found_index);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_ok !== want.ok) begin
                  $display("%0t: ok mismatch: expected %0b actual %0b", $time,
                           want.ok, rsp_ok);
                  error_count++;
               end
               if (rsp_found !== want.found) begin
                  $display("%0t: found mismatch: expected %0b actual %0b", $time,
                           want.found, rsp_found);
                  error_count++;
               end
               if (rsp_found_index !== want.found_index) begin
                  $display("%0t: found_index mismatch: expected %0d actual %0d", $time,
                           want.found_index, rsp_found_index);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            req_beats <= req_beats + 1;
            expected_results.push_back(apply_list_op(
               '{kind: req_kind, pos: req_position, value: req_value}));
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

@@ files.f @@
sv/psl_pkg.sv
sv/psl_cell.sv
sv/positional_shift_list_top.sv
sv/psl_checker.sv
test/tb_top.sv
